FILE: rtl/h3sp_pkg.sv
package h3sp_pkg;

  // Default number of declared session prefix slots
  localparam int PREFIX_SLOTS_DEF = 8;

  localparam int VAL_W = 62;

  // Item functions
  typedef enum logic [1:0] {
    FN_STREAM  = 2'd0,
    FN_DECLARE = 2'd1,
    FN_REMOVE  = 2'd2
  } func_t;

  // Result status codes
  typedef enum logic [3:0] {
    ST_PENDING      = 4'd0,
    ST_HDR_DONE     = 4'd1,
    ST_PAYLOAD      = 4'd2,
    ST_UNKNOWN_TYPE = 4'd3,
    ST_REFUSED_TYPE = 4'd4,
    ST_UNKNOWN_SESS = 4'd5,
    ST_DECLARED     = 4'd6,
    ST_DUPLICATE    = 4'd7,
    ST_FULL         = 4'd8,
    ST_REMOVED      = 4'd9,
    ST_NOT_FOUND    = 4'd10
  } status_t;

  // Per-stream header phase
  typedef enum logic [5:0] {
    PH_TYPE        = 6'b000001,
    PH_SESSION     = 6'b000010,
    PH_PAYLOAD     = 6'b000100,
    PH_ERR_UNKNOWN = 6'b001000,
    PH_ERR_REFUSED = 6'b010000,
    PH_ERR_SESSION = 6'b100000
  } phase_t;

  // Stream type codes
  localparam logic [VAL_W-1:0] TYPE_CONTROL   = 62'h00;
  localparam logic [VAL_W-1:0] TYPE_PUSH      = 62'h01;
  localparam logic [VAL_W-1:0] TYPE_QPACK_ENC = 62'h02;
  localparam logic [VAL_W-1:0] TYPE_QPACK_DEC = 62'h03;
  localparam logic [VAL_W-1:0] TYPE_WT_UNI    = 62'h54;
  localparam logic [VAL_W-1:0] TYPE_WT_BIDI   = 62'h41;

  typedef struct packed {
    logic [1:0]       func;
    logic             stream_start;
    logic             is_bidir;
    logic [7:0]       data_byte;
    logic [VAL_W-1:0] prefix_value;
  } h3sp_in_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [VAL_W-1:0] stream_type;
    logic [VAL_W-1:0] context_id;
    logic             is_webtransport;
    logic [2:0]       prefix_slot;
    logic [7:0]       payload_byte;
  } h3sp_out_t;

  // Prefix table lookup result handed to the header logic
  typedef struct packed {
    logic       hit;
    logic [2:0] slot;
  } pfx_look_t;

  // Varint length in bytes from the two top bits of its first byte
  function automatic logic [3:0] vlen(input logic [1:0] sel);
    logic [3:0] len;
    len = 4'd1 << sel;
    return len;
  endfunction

endpackage

FILE: rtl/http3_stream_header_parser.sv
// HTTP/3 incoming stream header parser with a session prefix table.
// in_item carries one stream byte (func stream), or a prefix to declare
// or remove. Each item yields exactly one out_item: its status, the decoded
// stream type, the WebTransport session id and table slot where they apply,
// and the byte itself once the header is done.
// Both channels are valid/ready. An item is registered on acceptance and
// is processed once the output register is free or being emptied, when its
// result is loaded into the output register. One item per cycle is
// sustained while out_ready stays high; the varint assembly and the
// parallel compare against all prefix slots sit between the input and
// output registers.
// When out_ready is low, the result holds; an item in the input register
// stays there and in_ready drops until the result is taken.
// Reset clears both valid bits, the stream header state and all prefix
// valid bits; the block accepts items in the first cycle after reset.
module http3_stream_header_parser import h3sp_pkg::*; #(
  parameter int PREFIX_SLOTS = PREFIX_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  h3sp_in_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output h3sp_out_t out_item
);

  logic             s1_valid;
  h3sp_in_t         s1_item;
  logic             adv;
  logic [VAL_W-1:0] sess_key;
  pfx_look_t        look;
  h3sp_out_t        fsm_res;
  h3sp_out_t        tbl_res;
  h3sp_out_t        res;

  // Process the held item when the output register is free
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  h3sp_header_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_item  (s1_item),
    .look     (look),
    .sess_key (sess_key),
    .res      (fsm_res)
  );

  h3sp_prefix_table #(
    .PREFIX_SLOTS (PREFIX_SLOTS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_item  (s1_item),
    .sess_key (sess_key),
    .look     (look),
    .res      (tbl_res)
  );

  // Select the result by function
  always_comb begin
    case (s1_item.func)
      FN_STREAM:  res = fsm_res;
      FN_DECLARE: res = tbl_res;
      FN_REMOVE:  res = tbl_res;
      default:    res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_adv_loads_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("processed item did not reach the output register");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while held item is stalled");

  a_payload_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_PAYLOAD |-> out_item.payload_byte == 8'd0)
    else $error("payload byte on a non-payload result");

  a_wt_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_webtransport |->
      out_item.status == ST_HDR_DONE || out_item.status == ST_UNKNOWN_SESS)
    else $error("session id reported without header completion");
`endif

endmodule

FILE: rtl/h3sp_prefix_table.sv
module h3sp_prefix_table import h3sp_pkg::*; #(
  parameter int PREFIX_SLOTS = PREFIX_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  h3sp_in_t         in_item,
  input  logic [VAL_W-1:0] sess_key,
  output pfx_look_t        look,
  output h3sp_out_t        res
);

  logic [VAL_W-1:0]        pfx_val [PREFIX_SLOTS];
  logic [PREFIX_SLOTS-1:0] pfx_valid;
  logic [PREFIX_SLOTS-1:0] pfx_valid_next;

  logic [VAL_W-1:0]        key;
  logic [PREFIX_SLOTS-1:0] hit_vec;
  logic [PREFIX_SLOTS-1:0] hit_one;
  logic [PREFIX_SLOTS-1:0] free_one;
  logic [PREFIX_SLOTS-1:0] wr_one;
  logic [PREFIX_SLOTS-1:0] clr_one;
  logic                    hit_any;
  logic                    free_any;
  logic [2:0]              hit_slot;
  logic [2:0]              free_slot;

  // Stream bytes look up the session id, table items their own prefix
  assign key = (in_item.func == FN_STREAM) ? sess_key : in_item.prefix_value;

  // Compare all slots in parallel
  always_comb begin
    for (int i = 0; i < PREFIX_SLOTS; i++) begin
      hit_vec[i] = pfx_valid[i] && (pfx_val[i] == key);
    end
  end

  // Pick the lowest matching and the lowest free slot
  always_comb begin
    hit_any   = 1'b0;
    hit_one   = '0;
    hit_slot  = '0;
    free_any  = 1'b0;
    free_one  = '0;
    free_slot = '0;
    for (int i = 0; i < PREFIX_SLOTS; i++) begin
      if (hit_vec[i] && !hit_any) begin
        hit_any    = 1'b1;
        hit_one[i] = 1'b1;
        hit_slot   = 3'(i);
      end
      if (!pfx_valid[i] && !free_any) begin
        free_any    = 1'b1;
        free_one[i] = 1'b1;
        free_slot   = 3'(i);
      end
    end
  end

  assign look.hit  = hit_any;
  assign look.slot = hit_slot;

  // Declare fills the lowest free slot, remove drops the matching one
  always_comb begin
    wr_one = '0;
    clr_one = '0;
    res = '0;
    case (in_item.func)
      FN_DECLARE: begin
        if (hit_any) begin
          res.status      = ST_DUPLICATE;
          res.prefix_slot = hit_slot;
        end else if (free_any) begin
          wr_one          = free_one;
          res.status      = ST_DECLARED;
          res.prefix_slot = free_slot;
        end else begin
          res.status = ST_FULL;
        end
      end
      FN_REMOVE: begin
        if (hit_any) begin
          clr_one         = hit_one;
          res.status      = ST_REMOVED;
          res.prefix_slot = hit_slot;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign pfx_valid_next = (pfx_valid | wr_one) & ~clr_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      pfx_valid <= '0;
    end else if (en) begin
      pfx_valid <= pfx_valid_next;
    end
  end

  // Prefix values carry no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < PREFIX_SLOTS; i++) begin
      if (en && wr_one[i]) begin
        pfx_val[i] <= key;
      end
    end
  end

endmodule

FILE: rtl/h3sp_header_fsm.sv
module h3sp_header_fsm import h3sp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  h3sp_in_t         in_item,
  input  pfx_look_t        look,
  output logic [VAL_W-1:0] sess_key,
  output h3sp_out_t        res
);

  phase_t           phase, phase_next, cur_phase;
  logic [3:0]       type_cnt, type_cnt_next, cur_tcnt;
  logic [3:0]       type_len, type_len_next, cur_tlen;
  logic [VAL_W-1:0] type_val, type_val_next, cur_type;
  logic [3:0]       sess_cnt, sess_cnt_next;
  logic [3:0]       sess_len, sess_len_next;
  logic [VAL_W-1:0] sess_acc, sess_acc_next;

  logic [7:0]       b;
  logic [3:0]       tcnt_inc;
  logic [3:0]       tlen_new;
  logic [VAL_W-1:0] type_new;
  logic [3:0]       scnt_inc;
  logic [3:0]       slen_new;
  logic [VAL_W-1:0] sess_new;

  assign b = in_item.data_byte;

  // Stream start clears the header state ahead of this byte
  always_comb begin
    cur_phase = phase;
    cur_tcnt  = type_cnt;
    cur_tlen  = type_len;
    cur_type  = type_val;
    if (in_item.stream_start) begin
      cur_phase = PH_TYPE;
      cur_tcnt  = '0;
      cur_tlen  = '0;
      cur_type  = '0;
    end
  end

  // Accumulate one varint byte for the type and for the session id
  assign tcnt_inc = cur_tcnt + 4'd1;
  assign tlen_new = (cur_tcnt == 4'd0) ? vlen(b[7:6]) : cur_tlen;
  assign type_new = (cur_tcnt == 4'd0) ? {56'b0, b[5:0]} : {cur_type[VAL_W-9:0], b};
  assign scnt_inc = sess_cnt + 4'd1;
  assign slen_new = (sess_cnt == 4'd0) ? vlen(b[7:6]) : sess_len;
  assign sess_new = (sess_cnt == 4'd0) ? {56'b0, b[5:0]} : {sess_acc[VAL_W-9:0], b};

  assign sess_key = sess_new;

  always_comb begin
    phase_next    = phase;
    type_cnt_next = type_cnt;
    type_len_next = type_len;
    type_val_next = type_val;
    sess_cnt_next = sess_cnt;
    sess_len_next = sess_len;
    sess_acc_next = sess_acc;
    res           = '0;
    if (in_item.func == FN_STREAM) begin
      phase_next    = cur_phase;
      type_cnt_next = cur_tcnt;
      type_len_next = cur_tlen;
      type_val_next = cur_type;
      case (cur_phase)
        PH_PAYLOAD: begin
          res.status       = ST_PAYLOAD;
          res.stream_type  = cur_type;
          res.payload_byte = b;
        end
        PH_ERR_UNKNOWN: res.status = ST_UNKNOWN_TYPE;
        PH_ERR_REFUSED: res.status = ST_REFUSED_TYPE;
        PH_ERR_SESSION: res.status = ST_UNKNOWN_SESS;
        PH_TYPE: begin
          type_cnt_next = tcnt_inc;
          type_len_next = tlen_new;
          type_val_next = type_new;
          // Classify the type once its last byte is in
          if (tcnt_inc == tlen_new) begin
            res.stream_type = type_new;
            sess_cnt_next   = '0;
            if (in_item.is_bidir) begin
              if (type_new == TYPE_WT_BIDI) begin
                phase_next = PH_SESSION;
              end else begin
                phase_next = PH_ERR_UNKNOWN;
                res.status = ST_UNKNOWN_TYPE;
              end
            end else if (type_new == TYPE_CONTROL || type_new == TYPE_QPACK_ENC ||
                         type_new == TYPE_QPACK_DEC) begin
              phase_next = PH_PAYLOAD;
              res.status = ST_HDR_DONE;
            end else if (type_new == TYPE_PUSH) begin
              phase_next = PH_ERR_REFUSED;
              res.status = ST_REFUSED_TYPE;
            end else if (type_new == TYPE_WT_UNI) begin
              phase_next = PH_SESSION;
            end else begin
              phase_next = PH_ERR_UNKNOWN;
              res.status = ST_UNKNOWN_TYPE;
            end
          end
        end
        PH_SESSION: begin
          res.stream_type = cur_type;
          sess_cnt_next   = scnt_inc;
          sess_len_next   = slen_new;
          sess_acc_next   = sess_new;
          // Look up the finished session id
          if (scnt_inc == slen_new) begin
            res.context_id      = sess_new;
            res.is_webtransport = 1'b1;
            if (look.hit) begin
              phase_next      = PH_PAYLOAD;
              res.status      = ST_HDR_DONE;
              res.prefix_slot = look.slot;
            end else begin
              phase_next = PH_ERR_SESSION;
              res.status = ST_UNKNOWN_SESS;
            end
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TYPE;
      type_cnt <= '0;
      type_len <= '0;
      type_val <= '0;
      sess_cnt <= '0;
      sess_len <= '0;
    end else if (en) begin
      phase    <= phase_next;
      type_cnt <= type_cnt_next;
      type_len <= type_len_next;
      type_val <= type_val_next;
      sess_cnt <= sess_cnt_next;
      sess_len <= sess_len_next;
    end
  end

  // Session accumulator needs no reset
  always_ff @(posedge clk) begin
    if (en) begin
      sess_acc <= sess_acc_next;
    end
  end

endmodule
